/* rtl/scfp_pkg.sv */
// ----------------------------------------------------------------------------
// scfp_pkg
// shared types and constants of the serial command frame parser
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int ByteW  = 8;
  localparam int LimitW = 4;
  localparam int WordW  = 24;
  localparam int IndexW = 2;

  typedef enum logic [IndexW-1:0] {
    CFG_START_DELIM = 2'd0,
    CFG_END_DELIM   = 2'd1,
    CFG_ROW_LIMIT   = 2'd2,
    CFG_COL_LIMIT   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_BYTE  = 2'd1,
    ECHO_LINE  = 2'd2,
    ECHO_UNREC = 2'd3
  } echo_kind_t;

  localparam logic [ByteW-1:0] ChE     = 8'h45;
  localparam logic [ByteW-1:0] ChN     = 8'h4e;
  localparam logic [ByteW-1:0] ChD     = 8'h44;
  localparam logic [ByteW-1:0] ChW     = 8'h57;
  localparam logic [ByteW-1:0] ChT     = 8'h54;
  localparam logic [ByteW-1:0] ChA     = 8'h41;
  localparam logic [ByteW-1:0] ChB     = 8'h42;
  localparam logic [ByteW-1:0] ChDash  = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;

  localparam logic [ByteW-1:0]  StartDelimRst = 8'h24;
  localparam logic [ByteW-1:0]  EndDelimRst   = 8'h21;
  localparam logic [LimitW-1:0] RowLimitRst   = 4'd7;
  localparam logic [LimitW-1:0] ColLimitRst   = 4'd7;

  typedef struct packed {
    logic              command_valid;
    logic [WordW-1:0]  command_word;
    echo_kind_t        echo_kind;
    logic [ByteW-1:0]  echo_byte;
    logic              error_flag;
  } result_t;

  function automatic logic digit_ok(input logic [ByteW-1:0] b,
                                    input logic [LimitW-1:0] limit);
    logic [ByteW-1:0] diff;
    diff = b - ChZero;
    return (b > ChZero) && (diff <= {{(ByteW-LimitW){1'b0}}, limit});
  endfunction

endpackage

/* rtl/serial_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// delimited three-byte command frame parser with echo and error level
// ----------------------------------------------------------------------------
// an accepted byte's result is registered in the out_ register, or in the skid register while out_stall holds it
// throughput: 1 byte per cycle while in_stall is low, set by the single frame-state update per byte
// a two-entry output buffer (result register plus skid) lets a byte be taken
// while the previous result waits; in_stall rises only when both are full
// reset: frame state, error level and buffers cleared, registers to defaults
// ----------------------------------------------------------------------------
module serial_command_frame_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [scfp_pkg::ByteW-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_command_valid,
  output logic [scfp_pkg::WordW-1:0] out_command_word,
  output logic [1:0]                 out_echo_kind,
  output logic [scfp_pkg::ByteW-1:0] out_echo_byte,
  output logic                       out_error_flag,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scfp_pkg::IndexW-1:0] cfg_index,
  input  logic [scfp_pkg::ByteW-1:0] cfg_data
);
  import scfp_pkg::*;

  logic [ByteW-1:0]  start_delim_r, end_delim_r;
  logic [LimitW-1:0] row_limit_r, col_limit_r;

  logic              in_frame_r, in_frame_nxt;
  logic [1:0]        count_r, count_nxt;
  logic [ByteW-1:0]  cmd_r [3];
  logic [ByteW-1:0]  cmd_nxt [3];
  logic              err_r, err_nxt;

  result_t           res, out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              take;

  logic [ByteW-1:0]  echo;
  echo_kind_t        kind;
  logic              frame_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= StartDelimRst;
      end_delim_r   <= EndDelimRst;
      row_limit_r   <= RowLimitRst;
      col_limit_r   <= ColLimitRst;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START_DELIM: start_delim_r <= cfg_data;
        CFG_END_DELIM:   end_delim_r   <= cfg_data;
        CFG_ROW_LIMIT:   row_limit_r   <= cfg_data[LimitW-1:0];
        CFG_COL_LIMIT:   col_limit_r   <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_ok = 1'b0;
    if (cmd_r[0] == ChE && cmd_r[1] == ChN && cmd_r[2] == ChD) frame_ok = 1'b1;
    if (cmd_r[0] == ChN && cmd_r[1] == ChE && cmd_r[2] == ChW) frame_ok = 1'b1;
    if (cmd_r[0] == ChT && cmd_r[1] == ChA && cmd_r[2] == ChB) frame_ok = 1'b1;
    if (cmd_r[1] == ChDash && digit_ok(cmd_r[0], row_limit_r) &&
        digit_ok(cmd_r[2], col_limit_r)) frame_ok = 1'b1;
  end

  always_comb begin
    echo         = (in_rx_byte == ChCr) ? ChLf : in_rx_byte;
    kind         = ECHO_NONE;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    cmd_nxt      = cmd_r;
    err_nxt      = err_r;
    res          = '0;
    if (!in_frame_r) begin
      if (in_rx_byte == start_delim_r) begin
        err_nxt      = 1'b0;
        in_frame_nxt = 1'b1;
        kind         = ECHO_BYTE;
      end
    end else if (in_rx_byte == end_delim_r) begin
      if (frame_ok) begin
        res.command_valid = 1'b1;
        res.command_word  = {cmd_r[2], cmd_r[1], cmd_r[0]};
        kind              = ECHO_LINE;
      end else begin
        kind = ECHO_UNREC;
      end
      in_frame_nxt = 1'b0;
      count_nxt    = 2'd0;
    end else if (count_r == 2'd3) begin
      count_nxt = 2'd0;
      err_nxt   = 1'b1;
    end else begin
      cmd_nxt[count_r] = in_rx_byte;
      count_nxt        = count_r + 2'd1;
      kind             = ECHO_BYTE;
    end
    // a zero byte is never echoed
    if ((kind == ECHO_BYTE || kind == ECHO_LINE) && echo == '0) kind = ECHO_NONE;
    res.echo_kind  = kind;
    res.echo_byte  = (kind == ECHO_BYTE || kind == ECHO_LINE) ? echo : '0;
    res.error_flag = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= 2'd0;
      cmd_r      <= '{default: '0};
      err_r      <= 1'b0;
    end else if (take) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      cmd_r      <= cmd_nxt;
      err_r      <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (take) begin
        out_r <= res;
      end
    end else if (take) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_valid = out_r.command_valid;
  assign out_command_word  = out_r.command_word;
  assign out_echo_kind     = out_r.echo_kind;
  assign out_echo_byte     = out_r.echo_byte;
  assign out_error_flag    = out_r.error_flag;

endmodule

/* rtl/scfp_checker.sv */
// ----------------------------------------------------------------------------
// scfp_checker
// port-level checks of the serial command frame parser
// ----------------------------------------------------------------------------
module scfp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_command_valid,
  input logic [scfp_pkg::WordW-1:0]  out_command_word,
  input logic [1:0]                  out_echo_kind,
  input logic [scfp_pkg::ByteW-1:0]  out_echo_byte
);
  import scfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_cmd_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_valid |-> out_echo_kind == ECHO_LINE ||
                                       out_echo_kind == ECHO_NONE)
    else $error("valid command without line echo");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_command_valid |-> out_command_word == '0)
    else $error("command word set without valid command");

  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_echo_kind == ECHO_NONE || out_echo_kind == ECHO_UNREC)
      |-> out_echo_byte == '0)
    else $error("echo byte set without echo request");

  a_stall_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_command_valid (out_command_valid),
  .out_command_word  (out_command_word),
  .out_echo_kind     (out_echo_kind),
  .out_echo_byte     (out_echo_byte)
);
